// ===== design/kwm_pkg.sv =====
// kwm_pkg: shared constants, types and hash step function for the k-mer
// window minimizer extractor; used by kwm_fifo, kwm_core and the top level
`default_nettype none
package kwm_pkg;

    localparam int KMER_LEN    = 15;
    localparam int WINDOW_LEN  = 10;
    localparam int DEDUP_DEPTH = 128;
    localparam int OUT_SLOTS   = 4;
    localparam int FIFO_DEPTH  = 4;

    localparam int HASH_W   = 2 * KMER_LEN;
    localparam int FULL_RUN = WINDOW_LEN + KMER_LEN;
    localparam int RUN_W    = $clog2(FULL_RUN + 1);
    localparam int POS_W    = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int DD_IDX_W = $clog2(DEDUP_DEPTH);
    localparam int DD_CNT_W = $clog2(DEDUP_DEPTH + 1);
    localparam int OCNT_W   = $clog2(OUT_SLOTS + 1);
    localparam int FIFO_AW  = $clog2(FIFO_DEPTH);
    localparam int MIX_STEPS = 7;
    localparam int HSTEP_W  = $clog2(MIX_STEPS);

    localparam logic [HASH_W-1:0] HMAX = '1;

    typedef struct packed {
        logic [HASH_W-1:0] h;
        logic              s;
    } entry_t;

    typedef struct packed {
        logic [2:0] base;
        logic       sor;
        logic       eor;
    } item_t;

    // one step of the invertible integer hash, all ops modulo 2^HASH_W
    function automatic logic [HASH_W-1:0] mix_step(input logic [HASH_W-1:0] k,
                                                   input logic [HSTEP_W-1:0] step);
        logic [HASH_W-1:0] r;
        begin
            case (step)
                HSTEP_W'(0): r = ~k + (k << 21);
                HSTEP_W'(1): r = k ^ (k >> 24);
                HSTEP_W'(2): r = k + (k << 3) + (k << 8);
                HSTEP_W'(3): r = k ^ (k >> 14);
                HSTEP_W'(4): r = k + (k << 2) + (k << 4);
                HSTEP_W'(5): r = k ^ (k >> 28);
                default:     r = k + (k << 31);
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

// ===== design/kwm_fifo.sv =====
// kwm_fifo: front end, accepts input transfers and queues them for the core
// depends on kwm_pkg
`default_nettype none
module kwm_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire kwm_pkg::item_t in_item,
    output logic                out_valid,
    input  wire logic           out_pop,
    output kwm_pkg::item_t      out_item
);
    import kwm_pkg::*;

    item_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wptr_reg;
    logic [FIFO_AW-1:0] rptr_reg;
    logic [FIFO_AW:0]   cnt_reg;
    logic               push;
    logic               pop;

    assign in_ready  = (cnt_reg != (FIFO_AW+1)'(FIFO_DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_item  = mem_reg[rptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= in_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= (wptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= (rptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

// ===== design/kwm_core.sv =====
// kwm_core: back end sequencer, k-mer update, hash, window scan, dedup
// search and result register; depends on kwm_pkg
`default_nettype none
module kwm_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_pop,
    input  wire kwm_pkg::item_t in_item,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [31:0]         m_tdata,
    output logic [1:0]          m_tuser,
    output logic                m_tlast
);
    import kwm_pkg::*;

    typedef enum logic [16:0] {
        S_IDLE     = 17'b00000000000000001,
        S_BASE     = 17'b00000000000000010,
        S_HASH     = 17'b00000000000000100,
        S_RINGW    = 17'b00000000000001000,
        S_CMP      = 17'b00000000000010000,
        S_SCAN     = 17'b00000000000100000,
        S_SCAN_END = 17'b00000000001000000,
        S_ADV      = 17'b00000000010000000,
        S_EOR      = 17'b00000000100000000,
        S_MARK     = 17'b00000001000000000,
        S_CLR      = 17'b00000010000000000,
        S_DONE     = 17'b00000100000000000,
        S_DD_START = 17'b00001000000000000,
        S_DD_RD    = 17'b00010000000000000,
        S_DD_CMP   = 17'b00100000000000000,
        S_DD_DEC   = 17'b01000000000000000,
        S_PUSH     = 17'b10000000000000000
    } state_t;

    state_t              state_reg;
    state_t              ret_reg;
    item_t               item_reg;
    logic [HASH_W-1:0]   fwd_reg;
    logic [HASH_W-1:0]   rev_reg;
    logic [RUN_W-1:0]    run_reg;
    entry_t              ring_reg [WINDOW_LEN];
    logic [POS_W-1:0]    pos_reg;
    logic [POS_W-1:0]    cpos_reg;
    entry_t              cur_reg;
    logic                mae_reg;
    logic                tp_reg;
    logic [DD_CNT_W-1:0] dd_cnt_reg;
    logic [DD_IDX_W-1:0] dd_idx_reg;
    entry_t              dd_mem [DEDUP_DEPTH];
    entry_t              dd_rdata_reg;
    entry_t              e_reg;
    logic [HSTEP_W-1:0]  hstep_reg;
    logic [POS_W-1:0]    scan_idx_reg;
    logic [POS_W-1:0]    scan_cnt_reg;
    logic                scan_tie_reg;
    entry_t              cand_reg;
    logic                cand_done_reg;
    logic                cand_drop_reg;
    logic [OCNT_W-1:0]   ocnt_reg;
    logic                pend_valid_reg;
    entry_t              pend_reg;
    logic                pend_done_reg;
    logic                pend_drop_reg;
    logic                out_valid_reg;
    entry_t              out_reg;
    logic                out_done_reg;
    logic                out_drop_reg;
    logic                out_last_reg;

    logic [HASH_W-1:0]   fwd_n;
    logic [HASH_W-1:0]   rev_n;
    logic [RUN_W-1:0]    run_n;
    logic [OCNT_W-1:0]   oavail;
    logic                out_free;
    logic                out_load;
    logic                dd_we;
    entry_t              scan_ent;

    assign fwd_n    = {fwd_reg[HASH_W-3:0], item_reg.base[1:0]};
    assign rev_n    = {~item_reg.base[1:0], rev_reg[HASH_W-1:2]};
    assign run_n    = (run_reg < RUN_W'(FULL_RUN)) ? run_reg + 1'b1 : run_reg;
    assign oavail   = item_reg.eor ? OCNT_W'(OUT_SLOTS - 1) : OCNT_W'(OUT_SLOTS);
    assign out_free = !out_valid_reg || m_tready;
    assign out_load = ((state_reg == S_PUSH) || (state_reg == S_DONE)) &&
                      pend_valid_reg && out_free;
    assign dd_we    = (state_reg == S_DD_DEC) && (ocnt_reg < oavail) &&
                      (dd_cnt_reg < DD_CNT_W'(DEDUP_DEPTH));
    assign scan_ent = ring_reg[scan_idx_reg];
    assign in_pop   = (state_reg == S_IDLE) && in_valid;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg.s, out_reg.h[29:0]};
    assign m_tuser  = {out_drop_reg, out_done_reg};
    assign m_tlast  = out_last_reg;

    // dedup table memory, registered read
    always_ff @(posedge clk)
    begin
        if (dd_we)
        begin
            dd_mem[dd_cnt_reg[DD_IDX_W-1:0]] <= cand_reg;
        end
        dd_rdata_reg <= dd_mem[dd_idx_reg];
    end

    // sequencer and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ret_reg        <= S_IDLE;
            fwd_reg        <= '0;
            rev_reg        <= '0;
            run_reg        <= '0;
            for (int i = 0; i < WINDOW_LEN; i++)
            begin
                ring_reg[i] <= '{h: HMAX, s: 1'b0};
            end
            pos_reg        <= '0;
            cpos_reg       <= '0;
            cur_reg        <= '{h: HMAX, s: 1'b0};
            mae_reg        <= 1'b0;
            tp_reg         <= 1'b0;
            dd_cnt_reg     <= '0;
            dd_idx_reg     <= '0;
            ocnt_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            // result register drains on transfer unless reloaded this cycle
            if (out_valid_reg && m_tready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        item_reg <= in_item;
                        ocnt_reg <= '0;
                        if (in_item.sor)
                        begin
                            fwd_reg    <= '0;
                            rev_reg    <= '0;
                            run_reg    <= '0;
                            for (int i = 0; i < WINDOW_LEN; i++)
                            begin
                                ring_reg[i] <= '{h: HMAX, s: 1'b0};
                            end
                            pos_reg    <= '0;
                            cpos_reg   <= '0;
                            cur_reg    <= '{h: HMAX, s: 1'b0};
                            mae_reg    <= 1'b0;
                            tp_reg     <= 1'b0;
                            dd_cnt_reg <= '0;
                        end
                        state_reg <= S_BASE;
                    end
                end

                S_BASE:
                begin
                    if (!item_reg.base[2])
                    begin
                        fwd_reg <= fwd_n;
                        rev_reg <= rev_n;
                        if (fwd_n == rev_n)
                        begin
                            // palindrome, skips ring write, compare and advance for this base
                            state_reg <= S_EOR;
                        end
                        else
                        begin
                            run_reg <= run_n;
                            if (run_n >= RUN_W'(KMER_LEN))
                            begin
                                e_reg.h   <= (fwd_n > rev_n) ? rev_n : fwd_n;
                                e_reg.s   <= (fwd_n > rev_n);
                                hstep_reg <= '0;
                                state_reg <= S_HASH;
                            end
                            else
                            begin
                                e_reg     <= '{h: HMAX, s: 1'b0};
                                state_reg <= S_RINGW;
                            end
                        end
                    end
                    else
                    begin
                        // ambiguous base
                        e_reg   <= '{h: HMAX, s: 1'b0};
                        run_reg <= '0;
                        if (run_reg >= RUN_W'(FULL_RUN - 1))
                        begin
                            mae_reg       <= 1'b1;
                            cand_reg      <= cur_reg;
                            cand_done_reg <= 1'b0;
                            ret_reg       <= S_RINGW;
                            state_reg     <= S_DD_START;
                        end
                        else
                        begin
                            state_reg <= S_RINGW;
                        end
                    end
                end

                S_HASH:
                begin
                    e_reg.h   <= mix_step(e_reg.h, hstep_reg);
                    hstep_reg <= hstep_reg + 1'b1;
                    if (hstep_reg == HSTEP_W'(MIX_STEPS - 1))
                    begin
                        state_reg <= S_RINGW;
                    end
                end

                S_RINGW:
                begin
                    ring_reg[pos_reg] <= e_reg;
                    if (run_reg == RUN_W'(FULL_RUN - 1) && tp_reg)
                    begin
                        tp_reg        <= 1'b0;
                        cand_reg      <= '{h: cur_reg.h, s: ~cur_reg.s};
                        cand_done_reg <= 1'b0;
                        ret_reg       <= S_CMP;
                        state_reg     <= S_DD_START;
                    end
                    else
                    begin
                        state_reg <= S_CMP;
                    end
                end

                S_CMP:
                begin
                    if (e_reg.h <= cur_reg.h)
                    begin
                        if (run_reg >= RUN_W'(FULL_RUN))
                        begin
                            cand_reg      <= cur_reg;
                            cand_done_reg <= 1'b0;
                            ret_reg       <= S_ADV;
                            state_reg     <= S_DD_START;
                        end
                        else
                        begin
                            tp_reg    <= (run_reg < RUN_W'(FULL_RUN - 1)) &&
                                         (e_reg.h == cur_reg.h) && (e_reg.s != cur_reg.s);
                            state_reg <= S_ADV;
                        end
                        cur_reg  <= e_reg;
                        cpos_reg <= pos_reg;
                        mae_reg  <= 1'b0;
                    end
                    else if (pos_reg == cpos_reg)
                    begin
                        // minimum leaves the window: rescan
                        cur_reg.h    <= HMAX;
                        scan_idx_reg <= (pos_reg == POS_W'(WINDOW_LEN - 1)) ? '0 :
                                        pos_reg + 1'b1;
                        scan_cnt_reg <= '0;
                        scan_tie_reg <= 1'b0;
                        if (run_reg >= RUN_W'(FULL_RUN - 1))
                        begin
                            cand_reg      <= cur_reg;
                            cand_done_reg <= 1'b0;
                            ret_reg       <= S_SCAN;
                            state_reg     <= S_DD_START;
                        end
                        else
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                    else
                    begin
                        state_reg <= S_ADV;
                    end
                end

                S_SCAN:
                begin
                    if (cur_reg.h > scan_ent.h)
                    begin
                        cur_reg      <= scan_ent;
                        cpos_reg     <= scan_idx_reg;
                        mae_reg      <= 1'b0;
                        scan_tie_reg <= 1'b0;
                    end
                    else if (cur_reg.h == scan_ent.h && cur_reg.h != HMAX)
                    begin
                        cpos_reg <= scan_idx_reg;
                        if (cur_reg.s != scan_ent.s)
                        begin
                            scan_tie_reg <= 1'b1;
                        end
                    end
                    scan_idx_reg <= (scan_idx_reg == POS_W'(WINDOW_LEN - 1)) ? '0 :
                                    scan_idx_reg + 1'b1;
                    scan_cnt_reg <= scan_cnt_reg + 1'b1;
                    if (scan_cnt_reg == POS_W'(WINDOW_LEN - 1))
                    begin
                        state_reg <= S_SCAN_END;
                    end
                end

                S_SCAN_END:
                begin
                    if (scan_tie_reg && run_reg >= RUN_W'(FULL_RUN - 1))
                    begin
                        cand_reg      <= '{h: cur_reg.h, s: ~cur_reg.s};
                        cand_done_reg <= 1'b0;
                        ret_reg       <= S_ADV;
                        state_reg     <= S_DD_START;
                    end
                    else
                    begin
                        state_reg <= S_ADV;
                    end
                end

                S_ADV:
                begin
                    pos_reg   <= (pos_reg == POS_W'(WINDOW_LEN - 1)) ? '0 : pos_reg + 1'b1;
                    state_reg <= S_EOR;
                end

                S_EOR:
                begin
                    if (!item_reg.eor)
                    begin
                        state_reg <= S_DONE;
                    end
                    else if (cur_reg.h != HMAX && !mae_reg)
                    begin
                        cand_reg      <= cur_reg;
                        cand_done_reg <= 1'b0;
                        ret_reg       <= S_MARK;
                        state_reg     <= S_DD_START;
                    end
                    else
                    begin
                        state_reg <= S_MARK;
                    end
                end

                S_MARK:
                begin
                    cand_reg      <= '{h: '0, s: 1'b0};
                    cand_done_reg <= 1'b1;
                    cand_drop_reg <= 1'b0;
                    ret_reg       <= S_CLR;
                    state_reg     <= S_PUSH;
                end

                S_CLR:
                begin
                    fwd_reg    <= '0;
                    rev_reg    <= '0;
                    run_reg    <= '0;
                    for (int i = 0; i < WINDOW_LEN; i++)
                    begin
                        ring_reg[i] <= '{h: HMAX, s: 1'b0};
                    end
                    pos_reg    <= '0;
                    cpos_reg   <= '0;
                    cur_reg    <= '{h: HMAX, s: 1'b0};
                    mae_reg    <= 1'b0;
                    tp_reg     <= 1'b0;
                    dd_cnt_reg <= '0;
                    state_reg  <= S_DONE;
                end

                S_DONE:
                begin
                    // last pending result leaves with tlast
                    if (!pend_valid_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_reg        <= pend_reg;
                        out_done_reg   <= pend_done_reg;
                        out_drop_reg   <= pend_drop_reg;
                        out_last_reg   <= 1'b1;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end

                S_DD_START:
                begin
                    dd_idx_reg <= '0;
                    state_reg  <= (dd_cnt_reg == '0) ? S_DD_DEC : S_DD_RD;
                end

                S_DD_RD:
                begin
                    state_reg <= S_DD_CMP;
                end

                S_DD_CMP:
                begin
                    if (dd_rdata_reg == cand_reg)
                    begin
                        state_reg <= ret_reg;
                    end
                    else if ({1'b0, dd_idx_reg} + 1'b1 == dd_cnt_reg)
                    begin
                        state_reg <= S_DD_DEC;
                    end
                    else
                    begin
                        dd_idx_reg <= dd_idx_reg + 1'b1;
                        state_reg  <= S_DD_RD;
                    end
                end

                S_DD_DEC:
                begin
                    if (ocnt_reg >= oavail)
                    begin
                        state_reg <= ret_reg;
                    end
                    else
                    begin
                        if (dd_cnt_reg < DD_CNT_W'(DEDUP_DEPTH))
                        begin
                            dd_cnt_reg    <= dd_cnt_reg + 1'b1;
                            cand_drop_reg <= 1'b0;
                        end
                        else
                        begin
                            cand_drop_reg <= 1'b1;
                        end
                        state_reg <= S_PUSH;
                    end
                end

                S_PUSH:
                begin
                    // hold one result back so tlast can mark the final one
                    if (!pend_valid_reg || out_free)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_reg <= 1'b1;
                            out_reg       <= pend_reg;
                            out_done_reg  <= pend_done_reg;
                            out_drop_reg  <= pend_drop_reg;
                            out_last_reg  <= 1'b0;
                        end
                        pend_valid_reg <= 1'b1;
                        pend_reg       <= cand_reg;
                        pend_done_reg  <= cand_done_reg;
                        pend_drop_reg  <= cand_drop_reg;
                        ocnt_reg       <= ocnt_reg + 1'b1;
                        state_reg      <= ret_reg;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== design/kmer_window_minimizer_extractor.sv =====
// kmer_window_minimizer_extractor: top level, input queue plus sequencing core
// depends on kwm_pkg, kwm_fifo, kwm_core
// each base passes the input queue, then the core updates the k-mer, hashes it once full,
//   compares it with the window minimum or rescans, and searches the dedup table per result
// throughput: one base at a time in the core; output stalls hold it in its push states
// reset: rst_n clears all control state and the window; dedup table needs no clearing
`default_nettype none
module kmer_window_minimizer_extractor (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // base[2:0], zero pad
    input  wire logic        s_tuser,   // start_of_read
    input  wire logic        s_tlast,   // end_of_read
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // minimizer_hash[29:0], strand[30], zero pad
    output logic [1:0]       m_tuser,   // read_done[0], dropped_full[1]
    output logic             m_tlast    // last_in_run
);
    import kwm_pkg::*;

    item_t in_item;
    item_t q_item;
    logic  q_valid;
    logic  q_pop;

    assign in_item = '{base: s_tdata[2:0], sor: s_tuser, eor: s_tlast};

    // front: input queue
    kwm_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .out_valid (q_valid),
        .out_pop   (q_pop),
        .out_item  (q_item)
    );

    // back: per-base sequencer
    kwm_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (q_valid),
        .in_pop   (q_pop),
        .in_item  (q_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );
endmodule
`default_nettype wire

// ===== tb/tb_kmer_window_minimizer_extractor.sv =====
// tb_kmer_window_minimizer_extractor: self-checking bench for the minimizer extractor
// streams bases, predicts minimizer transfers with its own sketch model, checks each one
// depends on kwm_pkg and kmer_window_minimizer_extractor
`default_nettype none
module tb_kmer_window_minimizer_extractor;
    timeunit 1ns;
    timeprecision 1ps;
    import kwm_pkg::*;

    localparam logic [63:0] KEY_MASK = 64'h3FFF_FFFF;

    typedef struct packed {
        logic [29:0] h;
        logic        s;
    } pair_t;

    typedef struct packed {
        logic [29:0] h;
        logic        s;
        logic        done;
        logic        dropped;
        logic        last;
    } mnz_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    item_t bases_to_send[$];
    mnz_t  expected_mnz[$];
    int    errors = 0;
    int    bases_sent = 0;
    int    mnz_seen = 0;
    int    drops_seen = 0;
    int    cycle_no = 0;
    bit    stim_done = 1'b0;
    bit    took_base = 1'b0;

    // sketch state
    logic [29:0] fwd_kmer, rev_kmer;
    int          run_len;
    pair_t       ring [WINDOW_LEN];
    int          ring_pos, min_pos;
    pair_t       win_min;
    bit          min_sent, tie_wait;
    pair_t       seen_pairs [DEDUP_DEPTH];
    int          seen_cnt;
    mnz_t        step_out [$];
    int          out_room;

    kmer_window_minimizer_extractor i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #6 clk = ~clk;

    function automatic logic [29:0] kmer_hash(input logic [29:0] key);
        logic [63:0] k;
        begin
            k = {34'd0, key};
            k = (~k + (k << 21)) & KEY_MASK;
            k = (k ^ (k >> 24)) & KEY_MASK;
            k = (k + (k << 3) + (k << 8)) & KEY_MASK;
            k = (k ^ (k >> 14)) & KEY_MASK;
            k = (k + (k << 2) + (k << 4)) & KEY_MASK;
            k = (k ^ (k >> 28)) & KEY_MASK;
            k = (k + (k << 31)) & KEY_MASK;
            return k[29:0];
        end
    endfunction

    task automatic clear_read();
        fwd_kmer = '0;
        rev_kmer = '0;
        run_len = 0;
        for (int i = 0; i < WINDOW_LEN; i++)
            ring[i] = '{h: HMAX, s: 1'b0};
        ring_pos = 0;
        min_pos = 0;
        win_min = '{h: HMAX, s: 1'b0};
        min_sent = 0;
        tie_wait = 0;
        seen_cnt = 0;
    endtask

    // dedup against this read, then queue the pair if a slot is left
    task automatic offer_pair(input logic [29:0] h, input logic s);
        for (int i = 0; i < seen_cnt; i++)
            if (seen_pairs[i].h == h && seen_pairs[i].s == s)
                return;
        if (step_out.size() >= out_room)
            return;
        if (seen_cnt < DEDUP_DEPTH) begin
            seen_pairs[seen_cnt] = '{h: h, s: s};
            seen_cnt++;
            step_out.push_back('{h: h, s: s, done: 1'b0, dropped: 1'b0, last: 1'b0});
        end else
            step_out.push_back('{h: h, s: s, done: 1'b0, dropped: 1'b1, last: 1'b0});
    endtask

    task automatic shift_base(input logic [2:0] c);
        pair_t e;
        bit    tie;
        int    idx;
        e = '{h: HMAX, s: 1'b0};
        if (c < 3'd4) begin
            fwd_kmer = {fwd_kmer[27:0], c[1:0]};
            rev_kmer = {2'(3 ^ c[1:0]), rev_kmer[29:2]};
            // palindrome leaves run and ring untouched
            if (fwd_kmer == rev_kmer)
                return;
            if (run_len < FULL_RUN)
                run_len++;
            if (run_len >= KMER_LEN) begin
                e.s = fwd_kmer > rev_kmer;
                e.h = kmer_hash(e.s ? rev_kmer : fwd_kmer);
            end
        end else begin
            // ambiguous base flushes a full window
            if (run_len >= FULL_RUN - 1) begin
                offer_pair(win_min.h, win_min.s);
                min_sent = 1;
            end
            run_len = 0;
        end
        ring[ring_pos] = e;

        if (run_len == FULL_RUN - 1 && tie_wait) begin
            offer_pair(win_min.h, ~win_min.s);
            tie_wait = 0;
        end

        if (e.h <= win_min.h) begin
            if (run_len >= FULL_RUN)
                offer_pair(win_min.h, win_min.s);
            else if (run_len < FULL_RUN - 1 && e.h == win_min.h && e.s != win_min.s)
                tie_wait = 1;
            else
                tie_wait = 0;
            win_min = e;
            min_pos = ring_pos;
            min_sent = 0;
        end else if (ring_pos == min_pos) begin
            // minimum leaves the window: rescan
            tie = 0;
            if (run_len >= FULL_RUN - 1)
                offer_pair(win_min.h, win_min.s);
            win_min.h = HMAX;
            for (int j = 0; j < WINDOW_LEN; j++) begin
                idx = (ring_pos + 1 + j) % WINDOW_LEN;
                if (win_min.h > ring[idx].h) begin
                    win_min = ring[idx];
                    min_pos = idx;
                    min_sent = 0;
                    tie = 0;
                end else if (win_min.h == ring[idx].h && win_min.h != HMAX) begin
                    min_pos = idx;
                    if (win_min.s != ring[idx].s)
                        tie = 1;
                end
            end
            if (tie && run_len >= FULL_RUN - 1)
                offer_pair(win_min.h, ~win_min.s);
        end
        ring_pos = (ring_pos >= WINDOW_LEN - 1) ? 0 : ring_pos + 1;
    endtask

    task automatic predict_base(input item_t it);
        step_out.delete();
        out_room = it.eor ? OUT_SLOTS - 1 : OUT_SLOTS;
        if (it.sor)
            clear_read();
        shift_base(it.base);
        if (it.eor) begin
            if (win_min.h != HMAX && !min_sent)
                offer_pair(win_min.h, win_min.s);
            step_out.push_back('{h: '0, s: 1'b0, done: 1'b1, dropped: 1'b0, last: 1'b0});
            clear_read();
        end
        if (step_out.size() > 0)
            step_out[step_out.size() - 1].last = 1'b1;
        foreach (step_out[i])
            expected_mnz.push_back(step_out[i]);
    endtask

    task automatic add_base(input int c, input bit sor, input bit eor);
        bases_to_send.push_back('{base: 3'(c), sor: sor, eor: eor});
    endtask

    // one read with random content; amb_pct sets the share of ambiguous bases
    task automatic add_read(input int len, input int amb_pct, input bit with_sor);
        for (int i = 0; i < len; i++)
            add_base(($urandom_range(99) < amb_pct) ? $urandom_range(7, 4) : $urandom_range(3),
                     with_sor && i == 0, i == len - 1);
    endtask

    // check output transfers first, then predict any accepted input transfer
    always @(posedge clk) begin
        mnz_t want;
        cycle_no <= cycle_no + 1;
        if (rst_n && m_tvalid && m_tready) begin
            mnz_seen++;
            if (m_tuser[1])
                drops_seen++;
            if (expected_mnz.size() == 0) begin
                errors++;
                $display("%0t: unexpected transfer, actual hash %h strand %b user %b last %b",
                         $time, m_tdata[29:0], m_tdata[30], m_tuser, m_tlast);
            end else begin
                want = expected_mnz.pop_front();
                if (m_tdata[29:0] !== want.h || m_tdata[30] !== want.s
                    || m_tuser[0] !== want.done || m_tuser[1] !== want.dropped
                    || m_tlast !== want.last) begin
                    errors++;
                    $display("%0t: mismatch, expected hash %h strand %b done %b drop %b last %b",
                             $time, want.h, want.s, want.done, want.dropped, want.last);
                    $display("%0t:          actual   hash %h strand %b done %b drop %b last %b",
                             $time, m_tdata[29:0], m_tdata[30], m_tuser[0], m_tuser[1],
                             m_tlast);
                end
            end
        end
        took_base <= 1'b0;
        if (rst_n && s_tvalid && s_tready) begin
            predict_base('{base: s_tdata[2:0], sor: s_tuser, eor: s_tlast});
            bases_sent++;
            took_base <= 1'b1;
        end
    end

    // base driver and sink ready, random gaps except during a quiet stretch
    always @(negedge clk) begin
        item_t it;
        bit    quiet;
        quiet = cycle_no > 3000 && cycle_no < 9000;
        if (rst_n && (!s_tvalid || took_base)) begin
            if (bases_to_send.size() > 0 && (quiet || $urandom_range(99) >= 17)) begin
                it = bases_to_send.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {5'd0, it.base};
                s_tuser  <= it.sor;
                s_tlast  <= it.eor;
            end else
                s_tvalid <= 1'b0;
        end
        if (rst_n)
            m_tready <= quiet || $urandom_range(99) >= 17;
    end

    initial begin
        int rlen;
        clear_read();
        // directed: all bases, long homopolymer, ambiguous at full window
        add_base(0, 1, 1);
        add_base(7, 1, 1);
        for (int c = 0; c < 8; c++)
            add_base(c, c == 0, c == 7);
        for (int i = 0; i < 30; i++)
            add_base(i < 27 ? 0 : 3, i == 0, 0);
        add_base(4, 0, 0);
        add_base(2, 0, 1);
        // broken sequences: read with no start flag, start mid-read
        add_read(8, 0, 0);
        for (int i = 0; i < 20; i++)
            add_base($urandom_range(3), i == 0 || i == 12, i == 19);
        // random reads, mostly clean
        while (bases_to_send.size() < 100) begin
            rlen = ($urandom_range(9) == 0) ? $urandom_range(5, 1) : $urandom_range(70, 15);
            add_read(rlen, ($urandom_range(3) == 0) ? 8 : 0, $urandom_range(19) != 0);
        end
        // repetitive read for ties and duplicates
        for (int i = 0; i < 60; i++)
            add_base((i % 7) < 4 ? (i % 7) : 3 - (i % 3), i == 0, i == 59);
        // long read that grows the dedup table
        add_read(150, 0, 1);

        repeat (5) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        while (bases_to_send.size() > 0 || (s_tvalid && !took_base))
            @(posedge clk);
        while (expected_mnz.size() > 0)
            @(posedge clk);
        repeat (300) @(posedge clk);

        $display("tb: %0d bases sent, %0d minimizer transfers checked, %0d with table-full drop",
                 bases_sent, mnz_seen, drops_seen);
        if (errors == 0 && expected_mnz.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #40ms;
        $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
design/kwm_pkg.sv
design/kwm_fifo.sv
design/kwm_core.sv
design/kmer_window_minimizer_extractor.sv
tb/tb_kmer_window_minimizer_extractor.sv
